// ----- design/assert_macros.svh -----
// Assertion macros shared by the allocator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// antecedent holds -> consequent holds in the same cycle
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// antecedent holds -> consequent holds in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- design/bha_pkg.sv -----
// Shared constants, status codes, FSM state type and controller/datapath structs
// for the bitmap heap allocator. No dependencies.
`default_nettype none

package bha_pkg;

    localparam int HEAP_BYTES = 4096;             // usage map depth in bits
    localparam int WORD_W     = 32;               // map word width
    localparam int CHUNK_W    = 8;                // bits examined per scan cycle
    localparam int MAP_WORDS  = HEAP_BYTES / WORD_W;
    localparam int WADDR_W    = $clog2(MAP_WORDS);
    localparam int BIT_W      = $clog2(HEAP_BYTES);
    localparam int BOFF_W     = $clog2(WORD_W);
    localparam int CBIT_W     = $clog2(CHUNK_W);
    localparam int SPOS_W     = BIT_W - CBIT_W;   // chunk position in the map
    localparam int CSEL_W     = BOFF_W - CBIT_W;  // chunk select within a word
    localparam int SIZE_W     = 13;
    localparam int ADDR_W     = 17;
    localparam int STACK_W    = 16;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 1;

    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OOM    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BOUNDS = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DOUBLE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_STACK_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_SIZE  = 1'b1;

    localparam logic [SIZE_W-1:0] HEAP_SIZE_RST = SIZE_W'(HEAP_BYTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_RNG_RD,
        S_RNG_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                load_req;
        logic                scan_init;
        logic                scan_rd;
        logic                chunk_adv;
        logic                mark_init;
        logic                free_init;
        logic                rng_rd;
        logic                rng_wr;
        logic                rng_adv;
        logic                out_load;
        logic [STATUS_W-1:0] out_status;
    } cmd_t;

    typedef struct packed {
        logic req_mode;       // 1: free
        logic size_zero;
        logic out_of_bounds;
        logic chunk_found;
        logic chunk_oom;
        logic scan_last;
        logic chunk_wrap;
        logic rng_last_word;
        logic free_double;
        logic out_busy;
    } stat_t;

endpackage

`default_nettype wire

// ----- design/bitmap_heap_allocator.sv -----
// Top level of the bitmap heap allocator: stream ports, config port, checks.
// Depends on bha_pkg, bha_ctrl, bha_datapath and assert_macros.svh.
//
// First-fit byte allocator over a 4096-bit usage map (one bit per heap byte),
// held as 128 words of 32 bits with a per-word valid flag, so the map reads
// all free right after reset with no clearing pass. One request is in work
// at a time; s_tready is high only while the block waits for a request,
// and the result sits in an output register so the next request can be
// taken while it waits. Allocate: after setup (accept, then dispatch), the
// scanner reads one map word and checks it eight bits per cycle, word by
// word up to the first fitting run; then each map word touched is read and
// written back to mark the run, and the result is handed over. Free: each
// map word touched is read and written back (read-modify-write on the
// single map port). Zero-size and out-of-bounds requests finish without
// touching the map.
// block_address is the absolute start (stack_size + heap offset) on a good
// allocate, zero otherwise. Status: 0 ok, 1 out of memory, 2 zero size,
// 3 out of bounds, 4 double free (bytes before the first free one are
// already released). Config writes are meant for idle periods only.
`default_nettype none

`include "assert_macros.svh"

module bitmap_heap_allocator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [16:0] free_address, [29:17] req_size
    input  wire logic [0:0]  s_tuser,   // [0] mode (0 allocate, 1 free)
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [16:0] block_address
    output logic [2:0]       m_tuser,   // [2:0] status
    // config write port: index 0 stack_size, index 1 heap_size
    input  wire logic        cfg_wr_en,
    input  wire logic [0:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata
);

    bha_pkg::cmd_t  cmd;
    bha_pkg::stat_t stat;

    logic [bha_pkg::ADDR_W-1:0] block_address;

    bha_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bha_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .req_mode_in     (s_tuser[0]),
        .free_address_in (s_tdata[16:0]),
        .req_size_in     (s_tdata[29:17]),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .block_address   (block_address),
        .status          (m_tuser)
    );

    assign m_tdata = {7'b0, block_address};

    // one request at a time: after a transfer in, the input side closes
    `ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready, "request accepted while busy")
    // a pending result is never overwritten
    `ASSERT_SAME(a_no_overwrite, aclk, aresetn, cmd.out_load, !(m_tvalid && !m_tready), "result overwritten")
    // every map write is the second half of a read-modify-write
    `ASSERT_SAME(a_rmw_order, aclk, aresetn, cmd.rng_wr, $past(cmd.rng_rd), "map write without read")
    // the single map port never reads and writes in one cycle
    `ASSERT_SAME(a_one_port, aclk, aresetn, cmd.rng_wr, !(cmd.scan_rd || cmd.rng_rd), "map port conflict")

endmodule

`default_nettype wire

// ----- design/bha_ctrl.sv -----
// Controller FSM for the bitmap heap allocator.
// Depends on bha_pkg; drives bha_datapath through cmd_t, reads stat_t.
`default_nettype none

module bha_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire bha_pkg::stat_t  stat,
    output bha_pkg::cmd_t        cmd
);

    bha_pkg::state_t state_reg, state_next;
    logic [bha_pkg::STATUS_W-1:0] done_status_reg, done_status_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= bha_pkg::S_IDLE;
            done_status_reg <= bha_pkg::ST_OK;
        end else begin
            state_reg       <= state_next;
            done_status_reg <= done_status_next;
        end
    end

    // next state
    always_comb begin
        state_next       = state_reg;
        done_status_next = done_status_reg;
        unique case (state_reg)
            bha_pkg::S_IDLE: begin
                if (s_tvalid) state_next = bha_pkg::S_DISPATCH;
            end
            bha_pkg::S_DISPATCH: begin
                if (!stat.req_mode) begin
                    if (stat.size_zero) begin
                        state_next       = bha_pkg::S_DONE;
                        done_status_next = bha_pkg::ST_ZERO;
                    end else begin
                        state_next = bha_pkg::S_SCAN_RD;
                    end
                end else if (stat.out_of_bounds) begin
                    state_next       = bha_pkg::S_DONE;
                    done_status_next = bha_pkg::ST_BOUNDS;
                end else if (stat.size_zero) begin
                    state_next       = bha_pkg::S_DONE;
                    done_status_next = bha_pkg::ST_OK;
                end else begin
                    state_next = bha_pkg::S_RNG_RD;
                end
            end
            bha_pkg::S_SCAN_RD: state_next = bha_pkg::S_SCAN_CHK;
            bha_pkg::S_SCAN_CHK: begin
                if (stat.chunk_found) begin
                    state_next = bha_pkg::S_RNG_RD;
                end else if (stat.chunk_oom || stat.scan_last) begin
                    state_next       = bha_pkg::S_DONE;
                    done_status_next = bha_pkg::ST_OOM;
                end else if (stat.chunk_wrap) begin
                    state_next = bha_pkg::S_SCAN_RD;
                end
            end
            bha_pkg::S_RNG_RD: state_next = bha_pkg::S_RNG_WR;
            bha_pkg::S_RNG_WR: begin
                if (stat.req_mode && stat.free_double) begin
                    state_next       = bha_pkg::S_DONE;
                    done_status_next = bha_pkg::ST_DOUBLE;
                end else if (stat.rng_last_word) begin
                    state_next       = bha_pkg::S_DONE;
                    done_status_next = bha_pkg::ST_OK;
                end else begin
                    state_next = bha_pkg::S_RNG_RD;
                end
            end
            bha_pkg::S_DONE: begin
                if (!stat.out_busy) state_next = bha_pkg::S_IDLE;
            end
            default: state_next = bha_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd            = '0;
        cmd.out_status = done_status_reg;
        s_tready       = 1'b0;
        unique case (state_reg)
            bha_pkg::S_IDLE: begin
                s_tready     = 1'b1;
                cmd.load_req = s_tvalid;
            end
            bha_pkg::S_DISPATCH: begin
                cmd.scan_init = !stat.req_mode && !stat.size_zero;
                cmd.free_init = stat.req_mode && !stat.out_of_bounds && !stat.size_zero;
            end
            bha_pkg::S_SCAN_RD: cmd.scan_rd = 1'b1;
            bha_pkg::S_SCAN_CHK: begin
                cmd.mark_init = stat.chunk_found;
                cmd.chunk_adv = !stat.chunk_found && !stat.chunk_oom;
            end
            bha_pkg::S_RNG_RD: cmd.rng_rd = 1'b1;
            bha_pkg::S_RNG_WR: begin
                cmd.rng_wr  = 1'b1;
                cmd.rng_adv = !(stat.req_mode && stat.free_double) && !stat.rng_last_word;
            end
            bha_pkg::S_DONE: cmd.out_load = !stat.out_busy;
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- design/bha_datapath.sv -----
// Datapath for the bitmap heap allocator: config registers, usage map memory,
// chunk scanner, range marker/clearer and result register. Depends on bha_pkg.
`default_nettype none

module bha_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire bha_pkg::cmd_t                     cmd,
    output bha_pkg::stat_t                         stat,
    input  wire logic                              req_mode_in,
    input  wire logic [bha_pkg::ADDR_W-1:0]        free_address_in,
    input  wire logic [bha_pkg::SIZE_W-1:0]        req_size_in,
    input  wire logic                              cfg_wr_en,
    input  wire logic [bha_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [bha_pkg::STACK_W-1:0]       cfg_wdata,
    input  wire logic                              m_tready,
    output logic                                   m_tvalid,
    output logic [bha_pkg::ADDR_W-1:0]             block_address,
    output logic [bha_pkg::STATUS_W-1:0]           status
);

    localparam int WORD_W  = bha_pkg::WORD_W;
    localparam int CHUNK_W = bha_pkg::CHUNK_W;
    localparam int CBW     = bha_pkg::CBIT_W;
    localparam int SIZE_W  = bha_pkg::SIZE_W;
    localparam int ADDR_W  = bha_pkg::ADDR_W;
    localparam int BIT_W   = bha_pkg::BIT_W;
    localparam int BOFF_W  = bha_pkg::BOFF_W;
    localparam int CSEL_W  = bha_pkg::CSEL_W;
    localparam int WADDR_W = bha_pkg::WADDR_W;

    // configuration
    logic [bha_pkg::STACK_W-1:0] stack_size_reg;
    logic [SIZE_W-1:0]           heap_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stack_size_reg <= '0;
            heap_size_reg  <= bha_pkg::HEAP_SIZE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                bha_pkg::REG_STACK_SIZE: stack_size_reg <= cfg_wdata;
                bha_pkg::REG_HEAP_SIZE:  heap_size_reg  <= cfg_wdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    logic [SIZE_W-1:0] eff_heap;
    assign eff_heap = (heap_size_reg > bha_pkg::HEAP_SIZE_RST) ? bha_pkg::HEAP_SIZE_RST
                                                                 : heap_size_reg;

    // latched request
    logic              req_mode_reg;
    logic [ADDR_W-1:0] req_addr_reg;
    logic [SIZE_W-1:0] req_size_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_mode_reg <= req_mode_in;
            req_addr_reg <= free_address_in;
            req_size_reg <= req_size_in;
        end
    end

    // bounds check for free
    logic [ADDR_W-1:0] stack_ext, limit;
    logic [ADDR_W:0]   end_sum;
    logic              oob;

    assign stack_ext = ADDR_W'(stack_size_reg);
    assign limit     = stack_ext + ADDR_W'(eff_heap);
    assign end_sum   = (ADDR_W+1)'(req_addr_reg) + (ADDR_W+1)'(req_size_reg);
    assign oob       = (req_addr_reg < stack_ext) || (req_addr_reg >= limit) ||
                       (end_sum > (ADDR_W+1)'(limit));

    // usage map memory; rows never written read as all free
    logic [WORD_W-1:0]    map_mem [bha_pkg::MAP_WORDS];
    logic [bha_pkg::MAP_WORDS-1:0] row_vld_reg;
    logic [WORD_W-1:0]    rd_data_reg;
    logic                 rd_vld_reg;
    logic                 rd_en;
    logic [WADDR_W-1:0]   rd_addr;
    logic [WORD_W-1:0]    wr_data;
    logic [WORD_W-1:0]    word_data;

    logic [bha_pkg::SPOS_W-1:0] scan_pos_reg;
    logic [SIZE_W-1:0]          run_reg;
    logic [BIT_W-1:0]           rng_first_reg, rng_last_reg;
    logic [WADDR_W-1:0]         cur_word_reg;

    assign rd_en     = cmd.scan_rd || cmd.rng_rd;
    assign rd_addr   = cmd.scan_rd ? scan_pos_reg[bha_pkg::SPOS_W-1:CSEL_W] : cur_word_reg;
    assign word_data = rd_vld_reg ? rd_data_reg : '0;

    always_ff @(posedge aclk) begin
        if (cmd.rng_wr) map_mem[cur_word_reg] <= wr_data;
        if (rd_en) begin
            rd_data_reg <= map_mem[rd_addr];
            rd_vld_reg  <= row_vld_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) row_vld_reg <= '0;
        else if (cmd.rng_wr) row_vld_reg[cur_word_reg] <= 1'b1;
    end

    // chunk scanner: eight bits per cycle, run length carried across chunks
    logic [CHUNK_W-1:0] chunk;
    logic [SIZE_W-1:0]  run, idx;
    logic               found, oom, done;
    logic [BIT_W-1:0]   pos;
    logic [SIZE_W-1:0]  start_ext;

    assign chunk = word_data[scan_pos_reg[CSEL_W-1:0]*CHUNK_W +: CHUNK_W];

    always_comb begin
        run   = run_reg;
        found = 1'b0;
        oom   = 1'b0;
        done  = 1'b0;
        pos   = '0;
        idx   = '0;
        for (int i = 0; i < CHUNK_W; i++) begin
            idx = {1'b0, scan_pos_reg, CBW'(i)};
            if (!done) begin
                if (idx >= eff_heap) begin
                    oom  = 1'b1;
                    done = 1'b1;
                end else if (chunk[i]) begin
                    run = '0;
                end else begin
                    run = run + SIZE_W'(1);
                    if (run == req_size_reg) begin
                        found = 1'b1;
                        done  = 1'b1;
                        pos   = idx[BIT_W-1:0];
                    end
                end
            end
        end
    end

    assign start_ext = SIZE_W'(pos) + SIZE_W'(1) - req_size_reg;

    // free range
    logic [ADDR_W-1:0] free_base_ext;
    logic [SIZE_W-1:0] free_last_ext;

    assign free_base_ext = req_addr_reg - stack_ext;
    assign free_last_ext = SIZE_W'(free_base_ext[BIT_W-1:0]) + req_size_reg - SIZE_W'(1);

    always_ff @(posedge aclk) begin
        if (cmd.scan_init) begin
            scan_pos_reg <= '0;
            run_reg      <= '0;
        end else if (cmd.chunk_adv) begin
            scan_pos_reg <= scan_pos_reg + 1'b1;
            run_reg      <= run;
        end
        if (cmd.mark_init) begin
            rng_first_reg <= start_ext[BIT_W-1:0];
            rng_last_reg  <= pos;
            cur_word_reg  <= start_ext[BIT_W-1:BOFF_W];
        end else if (cmd.free_init) begin
            rng_first_reg <= free_base_ext[BIT_W-1:0];
            rng_last_reg  <= free_last_ext[BIT_W-1:0];
            cur_word_reg  <= free_base_ext[BIT_W-1:BOFF_W];
        end else if (cmd.rng_adv) begin
            cur_word_reg  <= cur_word_reg + 1'b1;
        end
    end

    // per-word range mask, set for alloc, clear-until-first-free for free
    logic [BOFF_W-1:0] lo, hi;
    logic [WORD_W-1:0] mask, zero_bits, low_bit, clr;
    logic              last_word;

    assign last_word = (cur_word_reg == rng_last_reg[BIT_W-1:BOFF_W]);
    assign lo   = (cur_word_reg == rng_first_reg[BIT_W-1:BOFF_W]) ?
                  rng_first_reg[BOFF_W-1:0] : '0;
    assign hi   = last_word ? rng_last_reg[BOFF_W-1:0] : '1;
    assign mask = ({WORD_W{1'b1}} << lo) & ({WORD_W{1'b1}} >> (BOFF_W'(WORD_W - 1) - hi));
    assign zero_bits = ~word_data & mask;
    assign low_bit   = zero_bits & (~zero_bits + WORD_W'(1));
    assign clr       = (zero_bits == '0) ? mask : (mask & (low_bit - WORD_W'(1)));
    assign wr_data   = req_mode_reg ? (word_data & ~clr) : (word_data | mask);

    // result register
    logic                         out_vld_reg;
    logic [ADDR_W-1:0]            out_addr_reg;
    logic [bha_pkg::STATUS_W-1:0] out_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) out_vld_reg <= 1'b0;
        else if (cmd.out_load) out_vld_reg <= 1'b1;
        else if (m_tready) out_vld_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_status_reg <= cmd.out_status;
            out_addr_reg   <= (cmd.out_status == bha_pkg::ST_OK && !req_mode_reg) ?
                              stack_ext + ADDR_W'(rng_first_reg) : '0;
        end
    end

    assign m_tvalid      = out_vld_reg;
    assign block_address = out_addr_reg;
    assign status        = out_status_reg;

    always_comb begin
        stat.req_mode      = req_mode_reg;
        stat.size_zero     = (req_size_reg == '0);
        stat.out_of_bounds = oob;
        stat.chunk_found   = found;
        stat.chunk_oom     = oom;
        stat.scan_last     = (scan_pos_reg == '1);
        stat.chunk_wrap    = (scan_pos_reg[CSEL_W-1:0] == '1);
        stat.rng_last_word = last_word;
        stat.free_double   = (zero_bits != '0);
        stat.out_busy      = out_vld_reg && !m_tready;
    end

endmodule

`default_nettype wire

// ----- bench/tb_bitmap_heap_allocator.sv -----
// Self-checking bench for bitmap_heap_allocator: stream requests in, results out.
// Depends on bha_pkg (widths, status codes, register indexes) and the allocator RTL.
`timescale 1ns / 100ps

module tb_bitmap_heap_allocator;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam int ADDR_MASK      = (1 << bha_pkg::ADDR_W) - 1;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 600;    // long receiver hold-off
    localparam int SETTLE_CYCLES  = 20;     // quiet time before config writes and at end

    typedef struct {
        logic                       mode;
        logic [bha_pkg::ADDR_W-1:0] free_address;
        logic [bha_pkg::SIZE_W-1:0] req_size;
    } request_t;

    typedef struct {
        logic [bha_pkg::ADDR_W-1:0]   block_address;
        logic [bha_pkg::STATUS_W-1:0] status;
    } result_t;

    // heap-relative span of a block, so it survives a stack_size change
    typedef struct {
        int offset;
        int length;
    } span_t;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    wire                   s_tready;
    logic [31:0]           s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    wire                   m_tvalid;
    logic                  m_tready = 1'b0;
    wire  [23:0]           m_tdata;
    wire  [2:0]            m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [0:0]            cfg_addr = '0;
    logic [15:0]           cfg_wdata = '0;

    bitmap_heap_allocator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Allocator shadow: usage map plus the two registers as last written.
    // Updated at the same rising edges where the block sees the transfer.
    // ------------------------------------------------------------------
    bit                          byte_used [bha_pkg::HEAP_BYTES];
    logic [bha_pkg::STACK_W-1:0] shadow_stack = '0;
    logic [bha_pkg::SIZE_W-1:0]  shadow_heap  = bha_pkg::HEAP_SIZE_RST;

    request_t pending_requests[$];   // waiting for the driver
    result_t  awaited_results[$];    // predicted, not yet seen on m_*
    span_t    live_blocks[$];        // allocations believed to be held
    span_t    released_blocks[$];    // recently freed, used to provoke double frees

    int  queued_total = 0;
    int  results_seen = 0;
    int  mismatches   = 0;
    int  idle_cycles  = 0;
    bit  req_fire     = 1'b0;

    // sender / receiver knobs set by the stimulus thread
    int  gap_max      = 4;
    bit  hold_request = 1'b0;

    // stimulus-side view of the configuration
    int  gen_stack = 0;
    int  gen_span  = bha_pkg::HEAP_BYTES;
    int  live_target = 12;

    // heap bytes actually usable: heap_size saturates at the map depth
    function automatic int heap_span();
        return (int'(shadow_heap) > bha_pkg::HEAP_BYTES) ? bha_pkg::HEAP_BYTES
                                                          : int'(shadow_heap);
    endfunction

    function automatic void predict_request(input request_t r, output result_t res);
        int run;
        int first;
        int limit;
        int base;
        int size;
        int addr;
        bit done;
        size = int'(r.req_size);
        addr = int'(r.free_address);
        res.block_address = '0;
        res.status = bha_pkg::ST_OK;
        if (r.mode == MODE_ALLOC) begin
            if (size == 0) begin
                res.status = bha_pkg::ST_ZERO;
            end else begin
                // first fit: lowest run of free bytes long enough
                res.status = bha_pkg::ST_OOM;
                run = 0;
                done = 1'b0;
                for (int j = 0; j < heap_span() && !done; j++) begin
                    if (byte_used[j]) begin
                        run = 0;
                    end else begin
                        run++;
                        if (run == size) begin
                            first = j + 1 - size;
                            for (int k = first; k <= j; k++) byte_used[k] = 1'b1;
                            res.block_address = bha_pkg::ADDR_W'(
                                (int'(shadow_stack) + first) & ADDR_MASK);
                            res.status = bha_pkg::ST_OK;
                            live_blocks.push_back('{first, size});
                            done = 1'b1;
                        end
                    end
                end
            end
        end else begin
            limit = int'(shadow_stack) + heap_span();
            if (addr < int'(shadow_stack) || addr >= limit || addr + size > limit) begin
                res.status = bha_pkg::ST_BOUNDS;
            end else begin
                // release byte by byte; stop at the first one already free
                base = addr - int'(shadow_stack);
                for (int k = 0; k < size; k++) begin
                    if (!byte_used[base + k]) begin
                        res.status = bha_pkg::ST_DOUBLE;
                        break;
                    end
                    byte_used[base + k] = 1'b0;
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: samples at the rising edge. Config writes and accepted
    // requests feed the shadow; accepted results are checked in order.
    // Also runs the watchdog.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        request_t req;
        result_t  want;
        bit       res_fire;
        req_fire = s_tvalid && s_tready;
        res_fire = m_tvalid && m_tready;
        if (cfg_wr_en) begin
            if (cfg_addr == bha_pkg::REG_STACK_SIZE) shadow_stack = cfg_wdata;
            else shadow_heap = cfg_wdata[bha_pkg::SIZE_W-1:0];
        end
        if (req_fire) begin
            req.mode         = s_tuser[0];
            req.free_address = s_tdata[bha_pkg::ADDR_W-1:0];
            req.req_size     = s_tdata[bha_pkg::ADDR_W +: bha_pkg::SIZE_W];
            predict_request(req, want);
            awaited_results.push_back(want);
        end
        if (res_fire) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result, block_address %h status %0d",
                         $time, m_tdata[bha_pkg::ADDR_W-1:0], m_tuser);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                if (m_tdata[bha_pkg::ADDR_W-1:0] !== want.block_address) begin
                    $display("%0t: block_address expected %h actual %h",
                             $time, want.block_address, m_tdata[bha_pkg::ADDR_W-1:0]);
                    mismatches++;
                end
                if (m_tuser !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_tuser);
                    mismatches++;
                end
            end
        end
        if (req_fire || res_fire || cfg_wr_en) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: bursts of back-to-back requests separated by random gaps.
    // A request stays on the bus until the monitor saw it accepted.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : driver
        request_t item;
        int       burst_left;
        int       gap_left;
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left = $urandom_range(1, 24);
            gap_left   = 0;
        end else if (!s_tvalid || req_fire) begin
            if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                item = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, item.req_size, item.free_address};
                s_tuser  <= item.mode;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: m_tready follows a pattern that changes every so often;
    // a hold request forces one long stretch of back-pressure.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : receiver
        rx_pattern_t pattern;
        int          pattern_left;
        int          hold_left;
        if (!aresetn) begin
            m_tready     <= 1'b0;
            pattern      = RX_OPEN;
            pattern_left = 0;
            hold_left    = 0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern      = rx_pattern_t'($urandom_range(0, 3));
                pattern_left = $urandom_range(20, 200);
            end else begin
                pattern_left--;
            end
            case (pattern)
                RX_OPEN:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready <= ($urandom_range(0, 9) != 0);
                default:   m_tready <= pattern_left[2];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic post_request(input logic mode, input int addr, input int size);
        request_t r;
        r.mode         = mode;
        r.free_address = bha_pkg::ADDR_W'(addr & ADDR_MASK);
        r.req_size     = bha_pkg::SIZE_W'(size);
        pending_requests.push_back(r);
        queued_total++;
    endtask

    // sender pause: nothing new until every result is back
    task automatic await_all_results();
        while (results_seen < queued_total) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] index, input int value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= index;
        cfg_wdata <= 16'(value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // writes the registers only once the block is idle
    task automatic configure(input int stack, input int heap);
        await_all_results();
        write_reg(bha_pkg::REG_STACK_SIZE, stack);
        write_reg(bha_pkg::REG_HEAP_SIZE, heap);
        gen_stack = stack;
        gen_span  = (heap > bha_pkg::HEAP_BYTES) ? bha_pkg::HEAP_BYTES : heap;
    endtask

    task automatic alloc_random();
        int heap_max;
        int pick;
        int size;
        heap_max = (gen_span > 0) ? gen_span : 1;
        pick = $urandom_range(0, 99);
        if (pick < 80) size = $urandom_range(1, (heap_max < 48) ? heap_max : 48);
        else if (pick < 96) size = $urandom_range(1, heap_max);
        else size = $urandom_range(0, 1) ? heap_max : bha_pkg::HEAP_BYTES;
        post_request(MODE_ALLOC, $urandom_range(0, ADDR_MASK), size);
    endtask

    task automatic free_live(input int extra);
        int    idx;
        span_t blk;
        idx = $urandom_range(0, live_blocks.size() - 1);
        blk = live_blocks[idx];
        live_blocks.delete(idx);
        released_blocks.push_back(blk);
        if (released_blocks.size() > 8) void'(released_blocks.pop_front());
        post_request(MODE_FREE, gen_stack + blk.offset, blk.length + extra);
    endtask

    // malformed or boundary requests
    task automatic noise_request();
        int base;
        base = (gen_span > 0) ? $urandom_range(0, gen_span - 1) : 0;
        case ($urandom_range(0, 3))
            0: post_request(1'($urandom_range(0, 1)), $urandom_range(0, ADDR_MASK),
                            $urandom_range(0, 1) ? $urandom_range(0, 15)
                                                 : $urandom_range(0, bha_pkg::HEAP_BYTES));
            1: post_request(MODE_FREE, (gen_stack >= 16) ? gen_stack - $urandom_range(1, 16)
                                                         : $urandom_range(0, ADDR_MASK),
                            $urandom_range(1, 8));
            2: post_request(MODE_FREE, gen_stack + gen_span - $urandom_range(0, 4),
                            $urandom_range(1, 8));
            default: post_request(1'($urandom_range(0, 1)), gen_stack + base, 0);
        endcase
    endtask

    task automatic run_traffic(input int count);
        int roll;
        for (int i = 0; i < count; i++) begin
            while (pending_requests.size() >= 4) @(negedge aclk);
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                noise_request();
            end else if (roll < 15 && released_blocks.size() != 0) begin
                // free a block a second time
                roll = $urandom_range(0, released_blocks.size() - 1);
                post_request(MODE_FREE, gen_stack + released_blocks[roll].offset,
                             released_blocks[roll].length);
            end else if (roll < 18 && live_blocks.size() != 0) begin
                // free past the end of a block
                free_live($urandom_range(1, 8));
            end else if (live_blocks.size() == 0 ||
                         (live_blocks.size() < live_target && $urandom_range(0, 1))) begin
                alloc_random();
            end else begin
                free_live(0);
            end
            if ($urandom_range(0, 149) == 0) await_all_results();
        end
    endtask

    task automatic random_phase(input int stack, input int heap, input int count);
        configure(stack, heap);
        gap_max     = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
        live_target = $urandom_range(4, 24);
        run_traffic(count);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part, reset values of the registers: stack 0, heap 4096
        post_request(MODE_ALLOC, 0, 0);                       // zero size
        post_request(MODE_ALLOC, ADDR_MASK, 1);               // lands at 0
        post_request(MODE_ALLOC, 0, bha_pkg::HEAP_BYTES);     // out of memory
        post_request(MODE_FREE, 0, 1);
        post_request(MODE_ALLOC, 0, bha_pkg::HEAP_BYTES);     // whole heap
        post_request(MODE_ALLOC, 0, 1);                       // full heap
        post_request(MODE_FREE, 0, bha_pkg::HEAP_BYTES);
        post_request(MODE_FREE, 0, 1);                        // already free
        post_request(MODE_FREE, bha_pkg::HEAP_BYTES, 1);      // at heap end
        post_request(MODE_FREE, bha_pkg::HEAP_BYTES - 1, 2);  // runs past heap end
        post_request(MODE_FREE, 0, 0);                        // zero size in bounds
        post_request(MODE_FREE, ADDR_MASK, 0);
        post_request(MODE_ALLOC, 0, 8);
        post_request(MODE_ALLOC, 0, 8);
        post_request(MODE_FREE, 4, 8);
        post_request(MODE_ALLOC, 0, 4);
        post_request(MODE_FREE, 0, 12);                       // clears 0..7, trips on 8

        // heap_size above map depth saturates
        configure(100, 8191);
        post_request(MODE_FREE, 99, 1);                       // below heap start
        post_request(MODE_FREE, 112, 4);
        post_request(MODE_ALLOC, 0, bha_pkg::HEAP_BYTES);
        post_request(MODE_FREE, 100 + bha_pkg::HEAP_BYTES - 1, 1);
        post_request(MODE_ALLOC, 0, 1);
        post_request(MODE_ALLOC, 0, 1);
        post_request(MODE_FREE, 100, bha_pkg::HEAP_BYTES);

        configure(100, 0);                                    // empty heap
        post_request(MODE_ALLOC, 0, 1);
        post_request(MODE_FREE, 100, 0);

        await_all_results();
        live_blocks.delete();
        released_blocks.delete();

        // random part
        random_phase(0, bha_pkg::HEAP_BYTES, 150);
        random_phase(1234, 600, 150);

        // long back-pressure with the sender still pushing
        configure(65535, bha_pkg::HEAP_BYTES);
        gap_max     = 0;
        live_target = 16;
        run_traffic(10);
        hold_request = 1'b1;
        run_traffic(140);

        random_phase(0, 64, 150);
        random_phase(37, 8191, 120);
        random_phase(0, 0, 30);
        random_phase(65535, 1, 40);
        repeat (5) begin
            random_phase($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 65535),
                         $urandom_range(0, 3) == 0 ? $urandom_range(1, 64)
                                                   : $urandom_range(65, bha_pkg::HEAP_BYTES),
                         130);
        end

        await_all_results();
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/bha_pkg.sv
design/bha_ctrl.sv
design/bha_datapath.sv
design/bitmap_heap_allocator.sv
bench/tb_bitmap_heap_allocator.sv
